FILE: src/prmm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prmm_pkg
// shared types and constants of the paired read mate matcher
// ----------------------------------------------------------------------------
package prmm_pkg;

    localparam int NUM_W           = 32;
    localparam int POS_IN_W        = 32;
    localparam int TOTAL_W         = 32;
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_POS_WIDTH   = 32;

    typedef struct packed {
        logic [NUM_W-1:0]    pair_number;
        logic [POS_IN_W-1:0] read_start;
        logic [POS_IN_W-1:0] read_end;
        logic                read_strand;
    } t_read_req;

    typedef struct packed {
        logic                frag_valid;
        logic [POS_IN_W-1:0] frag_start;
        logic [POS_IN_W-1:0] frag_end;
        logic                mate_found;
        logic                is_duplicate;
        logic                table_overflow;
        logic [TOTAL_W-1:0]  duplicate_total;
        logic [TOTAL_W-1:0]  pair_total;
    } t_frag_result;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: src/prmm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prmm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module prmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: src/paired_read_mate_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// paired_read_mate_matcher
// pairs aligned reads with their waiting mates and builds fragments
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low. The read
// is looked up in the pending table by a sequencer that walks the table ram
// one entry per cycle through a single key comparator; the walk stops at the
// first matching entry or after the last one. The done state then frees the
// mate entry or stores the read (or flags table_overflow if no entry is free),
// and the result shows for one cycle on o_result with o_strobe high. A request
// takes longer the later its mate entry lies in the table, up to a full walk.
// busy stays high from the accept edge until the strobe cycle.
// The result has no back pressure: it must be taken in its strobe cycle.
// After reset a clearing pass marks every table entry free; busy is high
// during it. The accept_duplicates register is written on the cfg channel at
// any time, o_cfg_ready is always high, and it should only change while the
// block is idle.
// ----------------------------------------------------------------------------
module paired_read_mate_matcher #(
    parameter int TABLE_DEPTH = prmm_pkg::DEF_TABLE_DEPTH,
    parameter int POS_WIDTH   = prmm_pkg::DEF_POS_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire prmm_pkg::t_read_req    i_read,
    output logic                        o_strobe,
    output prmm_pkg::t_frag_result      o_result,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic                   i_cfg_data
);

    import prmm_pkg::*;

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int END_LO   = 1;
    localparam int START_LO = 1 + POS_WIDTH;
    localparam int NUM_LO   = 1 + 2 * POS_WIDTH;
    localparam int ENT_W    = 2 + NUM_W + 2 * POS_WIDTH;
    localparam int VLD_BIT  = ENT_W - 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_scan_addr, n_scan_addr;
    logic [IDX_W-1:0]      r_cmp_addr, n_cmp_addr;
    logic [IDX_W-1:0]      r_slot_addr, n_slot_addr;
    logic                  r_issuing, n_issuing;
    logic                  r_cmp_vld, n_cmp_vld;
    logic                  r_hit, n_hit;
    logic                  r_free_found, n_free_found;
    logic                  r_accept_dup;
    logic [POS_WIDTH-1:0]  r_last_start [2];
    logic [POS_WIDTH-1:0]  n_last_start [2];
    logic [TOTAL_W-1:0]    r_dup_cnt, n_dup_cnt;
    logic [TOTAL_W-1:0]    r_pair_cnt, n_pair_cnt;
    logic                  r_strobe, n_strobe;
    t_frag_result          r_result, n_result;

    t_read_req             r_req;
    logic                  capture_mate;
    logic [POS_WIDTH-1:0]  r_mate_start;
    logic [POS_WIDTH-1:0]  r_mate_end;
    logic                  r_mate_strand;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENT_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENT_W-1:0]      ram_rdata;

    logic                  ent_valid;
    logic [NUM_W-1:0]      ent_num;
    logic [POS_WIDTH-1:0]  req_start;
    logic [POS_WIDTH-1:0]  req_end;
    logic                  dup;
    logic                  emit;
    logic [POS_WIDTH-1:0]  frag_s;
    logic [POS_WIDTH-1:0]  frag_e;

    assign ent_valid = ram_rdata[VLD_BIT];
    assign ent_num   = ram_rdata[NUM_LO +: NUM_W];
    assign req_start = POS_WIDTH'(r_req.read_start);
    assign req_end   = POS_WIDTH'(r_req.read_end);

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    prmm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // pair resolution
    always_comb begin
        dup = (r_mate_start == r_last_start[r_mate_strand]) &&
              (req_start == r_last_start[r_req.read_strand]);
        emit = !dup || r_accept_dup;
        if (r_mate_strand) begin
            frag_s = r_mate_start;
            frag_e = req_end;
        end else begin
            frag_s = req_start;
            frag_e = r_mate_end;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_scan_addr  = r_scan_addr;
        n_cmp_addr   = r_cmp_addr;
        n_slot_addr  = r_slot_addr;
        n_issuing    = r_issuing;
        n_cmp_vld    = r_cmp_vld;
        n_hit        = r_hit;
        n_free_found = r_free_found;
        n_last_start = r_last_start;
        n_dup_cnt    = r_dup_cnt;
        n_pair_cnt   = r_pair_cnt;
        n_strobe     = 1'b0;
        n_result     = r_result;
        capture_mate = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_scan_addr;
        ram_wdata    = '0;
        ram_raddr    = r_scan_addr;

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_scan_addr == LAST_IDX) begin
                    n_scan_addr = '0;
                    n_state     = S_IDLE;
                end else begin
                    n_scan_addr = r_scan_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state      = S_SCAN;
                    n_scan_addr  = '0;
                    n_issuing    = 1'b1;
                    n_cmp_vld    = 1'b0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                end
            end
            S_SCAN: begin
                // read issue
                n_cmp_addr = r_scan_addr;
                n_cmp_vld  = r_issuing;
                if (r_issuing) begin
                    if (r_scan_addr == LAST_IDX) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_scan_addr = r_scan_addr + 1'b1;
                    end
                end
                // key compare on the returned entry
                if (r_cmp_vld) begin
                    if (ent_valid && (ent_num == r_req.pair_number)) begin
                        n_hit        = 1'b1;
                        n_slot_addr  = r_cmp_addr;
                        capture_mate = 1'b1;
                        n_issuing    = 1'b0;
                        n_state      = S_DONE;
                    end else begin
                        if (!ent_valid && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_slot_addr  = r_cmp_addr;
                        end
                        if (r_cmp_addr == LAST_IDX) begin
                            n_issuing = 1'b0;
                            n_state   = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                n_state                 = S_IDLE;
                n_strobe                = 1'b1;
                n_result                = '0;
                ram_waddr               = r_slot_addr;
                if (r_hit) begin
                    ram_we = 1'b1;
                    n_result.mate_found   = 1'b1;
                    n_result.is_duplicate = dup;
                    if (dup && (r_dup_cnt != '1)) begin
                        n_dup_cnt = r_dup_cnt + 1'b1;
                    end
                    if (r_pair_cnt != '1) begin
                        n_pair_cnt = r_pair_cnt + 1'b1;
                    end
                    if (emit) begin
                        n_result.frag_valid = 1'b1;
                        n_result.frag_start = POS_IN_W'(frag_s);
                        n_result.frag_end   = POS_IN_W'(frag_e);
                    end
                    n_last_start[r_mate_strand]    = r_mate_start;
                    n_last_start[r_req.read_strand] = req_start;
                end else if (r_free_found) begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, r_req.pair_number, req_start, req_end,
                                 r_req.read_strand};
                end else begin
                    n_result.table_overflow = 1'b1;
                end
                n_result.duplicate_total = n_dup_cnt;
                n_result.pair_total      = n_pair_cnt;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_scan_addr     <= '0;
            r_cmp_addr      <= '0;
            r_slot_addr     <= '0;
            r_issuing       <= 1'b0;
            r_cmp_vld       <= 1'b0;
            r_hit           <= 1'b0;
            r_free_found    <= 1'b0;
            r_accept_dup    <= 1'b0;
            r_last_start[0] <= '0;
            r_last_start[1] <= '0;
            r_dup_cnt       <= '0;
            r_pair_cnt      <= '0;
            r_strobe        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_scan_addr  <= n_scan_addr;
            r_cmp_addr   <= n_cmp_addr;
            r_slot_addr  <= n_slot_addr;
            r_issuing    <= n_issuing;
            r_cmp_vld    <= n_cmp_vld;
            r_hit        <= n_hit;
            r_free_found <= n_free_found;
            r_last_start <= n_last_start;
            r_dup_cnt    <= n_dup_cnt;
            r_pair_cnt   <= n_pair_cnt;
            r_strobe     <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_accept_dup <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (start && !busy) begin
            r_req <= i_read;
        end
        if (capture_mate) begin
            r_mate_start  <= ram_rdata[START_LO +: POS_WIDTH];
            r_mate_end    <= ram_rdata[END_LO +: POS_WIDTH];
            r_mate_strand <= ram_rdata[0];
        end
    end

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking testbench of the paired read mate matcher
// ----------------------------------------------------------------------------
// A queue-fed driver sends directed and random read requests. The random
// requests are mostly mate pairs, duplicate pairs and one full-table pass. An
// in-bench pairing table predicts every result. A monitor compares each
// strobed result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import prmm_pkg::*;

    localparam int DEPTH         = DEF_TABLE_DEPTH;
    localparam int GAP_MAX       = 4;
    localparam int SETTLE_CYCLES = DEPTH + 8;
    localparam int OPEN_CAP      = 40;

    typedef enum logic [1:0] {
        STEP_READ,
        STEP_CFG,
        STEP_DRAIN
    } t_step_kind;

    typedef struct {
        t_step_kind kind;
        t_read_req  req;
        logic       cfg_value;
    } t_step;

    logic         i_clk;
    logic         i_rst_n     = 1'b0;
    logic         start       = 1'b0;
    logic         busy;
    t_read_req    i_read      = '0;
    logic         o_strobe;
    t_frag_result o_result;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_data  = 1'b0;

    paired_read_mate_matcher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_read      (i_read),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // pairing table kept by the bench
    logic        slot_used   [DEPTH];
    logic [31:0] slot_number [DEPTH];
    logic [31:0] slot_start  [DEPTH];
    logic [31:0] slot_end    [DEPTH];
    logic        slot_strand [DEPTH];
    logic [31:0] last_start  [2];
    logic [31:0] dup_count;
    logic [31:0] pair_count;
    logic        accept_dups;

    t_frag_result frag_expect_q[$];
    t_step        plan_q[$];
    logic [31:0]  open_nums[$];
    int           n_errors = 0;
    int           n_sent   = 0;
    int           gap_left = 0;
    logic         gaps_on  = 1'b1;

    function automatic t_frag_result pair_read(t_read_req rd);
        t_frag_result res;
        int           hit;
        int           free_slot;
        logic [31:0]  ms;
        logic [31:0]  me;
        logic         mstr;
        logic         is_dup;
        res       = '0;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (slot_used[i]) begin
                if (hit < 0 && slot_number[i] == rd.pair_number) hit = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (hit < 0) begin
            if (free_slot < 0) begin
                res.table_overflow = 1'b1;
            end else begin
                slot_used[free_slot]   = 1'b1;
                slot_number[free_slot] = rd.pair_number;
                slot_start[free_slot]  = rd.read_start;
                slot_end[free_slot]    = rd.read_end;
                slot_strand[free_slot] = rd.read_strand;
            end
        end else begin
            ms     = slot_start[hit];
            me     = slot_end[hit];
            mstr   = slot_strand[hit];
            is_dup = (ms == last_start[mstr]) && (rd.read_start == last_start[rd.read_strand]);
            res.mate_found   = 1'b1;
            res.is_duplicate = is_dup;
            if (is_dup && dup_count != '1) dup_count = dup_count + 1;
            if (!is_dup || accept_dups) begin
                res.frag_valid = 1'b1;
                if (mstr) begin
                    res.frag_start = ms;
                    res.frag_end   = rd.read_end;
                end else begin
                    res.frag_start = rd.read_start;
                    res.frag_end   = me;
                end
            end
            // mate strand first, so a shared strand keeps this read's start
            last_start[mstr]           = ms;
            last_start[rd.read_strand] = rd.read_start;
            slot_used[hit]             = 1'b0;
            if (pair_count != '1) pair_count = pair_count + 1;
        end
        res.duplicate_total = dup_count;
        res.pair_total      = pair_count;
        return res;
    endfunction

    function automatic void add_read(logic [31:0] num, logic [31:0] rs, logic [31:0] re,
                                     logic strand);
        t_step s;
        s.kind            = STEP_READ;
        s.req.pair_number = num;
        s.req.read_start  = rs;
        s.req.read_end    = re;
        s.req.read_strand = strand;
        s.cfg_value       = 1'b0;
        plan_q.push_back(s);
    endfunction

    function automatic void add_cfg(logic value);
        t_step s;
        s.kind      = STEP_CFG;
        s.req       = '0;
        s.cfg_value = value;
        plan_q.push_back(s);
    endfunction

    function automatic void add_drain();
        t_step s;
        s.kind      = STEP_DRAIN;
        s.req       = '0;
        s.cfg_value = 1'b0;
        plan_q.push_back(s);
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] fresh_num();
        logic [31:0] num;
        bit          taken;
        do begin
            num   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom;
            taken = 1'b0;
            foreach (open_nums[i]) if (open_nums[i] == num) taken = 1'b1;
        end while (taken);
        return num;
    endfunction

    function automatic void open_new();
        logic [31:0] num;
        num = fresh_num();
        add_read(num, rand_pos(), rand_pos(), 1'($urandom_range(0, 1)));
        open_nums.push_back(num);
    endfunction

    function automatic void close_open(int idx);
        add_read(open_nums[idx], rand_pos(), rand_pos(), 1'($urandom_range(0, 1)));
        open_nums.delete(idx);
    endfunction

    // two pairs back to back on the same starts and strands
    function automatic void dup_pair_burst();
        logic [31:0] a;
        logic [31:0] b;
        logic        sa;
        logic        sb;
        logic [31:0] n1;
        logic [31:0] n2;
        a  = rand_pos();
        b  = rand_pos();
        sa = 1'($urandom_range(0, 1));
        sb = 1'($urandom_range(0, 1));
        if (sa == sb && $urandom_range(0, 1) == 0) b = a;
        n1 = fresh_num();
        n2 = fresh_num();
        add_read(n1, a, rand_pos(), sa);
        add_read(n1, b, rand_pos(), sb);
        add_read(n2, a, rand_pos(), sa);
        add_read(n2, b, rand_pos(), sb);
    endfunction

    function automatic void mixed_traffic(int n_items);
        int issued;
        int pick;
        issued = 0;
        while (issued < n_items) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                dup_pair_burst();
                issued += 4;
            end else if (pick < 4) begin
                open_new();
                close_open(open_nums.size() - 1);
                issued += 2;
            end else if ((pick < 12 && open_nums.size() < OPEN_CAP) || open_nums.size() == 0) begin
                open_new();
                issued++;
            end else begin
                close_open($urandom_range(0, open_nums.size() - 1));
                issued++;
            end
        end
    endfunction

    function automatic void fill_table();
        while (open_nums.size() < DEPTH) open_new();
        repeat (3) add_read(fresh_num(), rand_pos(), rand_pos(), 1'($urandom_range(0, 1)));
        close_open($urandom_range(0, DEPTH - 1));
        open_new();
        add_read(fresh_num(), rand_pos(), rand_pos(), 1'($urandom_range(0, 1)));
        while (open_nums.size() != 0) close_open($urandom_range(0, open_nums.size() - 1));
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            n_errors++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request driver
    always @(posedge i_clk) begin
        logic  next_start;
        logic  next_cfg_valid;
        t_step step;
        next_start     = start;
        next_cfg_valid = i_cfg_valid;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                accept_dups    = i_cfg_data;
                next_cfg_valid = 1'b0;
            end
            if (start && !busy) begin
                frag_expect_q.push_back(pair_read(i_read));
                next_start = 1'b0;
                n_sent++;
                if (n_sent % 64 == 0) gaps_on = ($urandom_range(0, 2) != 0);
                gap_left = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
            end
            if (!next_start && !next_cfg_valid && plan_q.size() != 0) begin
                step = plan_q[0];
                case (step.kind)
                    STEP_READ: begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            i_read     <= step.req;
                            next_start = 1'b1;
                            void'(plan_q.pop_front());
                        end
                    end
                    STEP_CFG: begin
                        if (frag_expect_q.size() == 0 && !busy) begin
                            i_cfg_data     <= step.cfg_value;
                            next_cfg_valid = 1'b1;
                            void'(plan_q.pop_front());
                        end
                    end
                    STEP_DRAIN: begin
                        if (frag_expect_q.size() == 0) void'(plan_q.pop_front());
                    end
                    default: void'(plan_q.pop_front());
                endcase
            end
        end
        start       <= next_start;
        i_cfg_valid <= next_cfg_valid;
    end

    // result monitor
    always @(posedge i_clk) begin
        t_frag_result want;
        if (i_rst_n && o_strobe) begin
            if (frag_expect_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_result);
                n_errors++;
            end else begin
                want = frag_expect_q.pop_front();
                check_field("frag_valid", 32'(want.frag_valid),
                            32'(o_result.frag_valid));
                check_field("frag_start", want.frag_start, o_result.frag_start);
                check_field("frag_end", want.frag_end, o_result.frag_end);
                check_field("mate_found", 32'(want.mate_found),
                            32'(o_result.mate_found));
                check_field("is_duplicate", 32'(want.is_duplicate),
                            32'(o_result.is_duplicate));
                check_field("table_overflow", 32'(want.table_overflow),
                            32'(o_result.table_overflow));
                check_field("duplicate_total", want.duplicate_total, o_result.duplicate_total);
                check_field("pair_total", want.pair_total, o_result.pair_total);
            end
        end
    end

    initial begin
        foreach (slot_used[i]) begin
            slot_used[i]   = 1'b0;
            slot_number[i] = '0;
            slot_start[i]  = '0;
            slot_end[i]    = '0;
            slot_strand[i] = 1'b0;
        end
        last_start[0] = '0;
        last_start[1] = '0;
        dup_count     = '0;
        pair_count    = '0;
        accept_dups   = 1'b0;

        add_cfg(1'b0);
        // both mates at the reset positions: a suppressed duplicate
        add_read(32'd0, 32'd0, 32'd0, 1'b0);
        add_read(32'd0, 32'd0, 32'd0, 1'b0);
        // all-ones fields, waiting mate on the plus strand
        add_read('1, '1, '1, 1'b1);
        add_read('1, 32'd0, '1, 1'b0);
        // end below start, waiting mate on the minus strand
        add_read(32'd5, 32'd100, 32'd50, 1'b0);
        add_read(32'd5, 32'd200, 32'd300, 1'b1);
        add_read(32'd6, 32'd100, 32'd7, 1'b0);
        add_read(32'd6, 32'd200, 32'd9, 1'b1);
        // middle mate leaves, its entry is reused
        add_read(32'd7, 32'd11, 32'd12, 1'b1);
        add_read(32'd8, 32'd13, 32'd14, 1'b0);
        add_read(32'd9, 32'd15, 32'd16, 1'b1);
        add_read(32'd8, 32'd17, 32'd18, 1'b1);
        add_read(32'd10, 32'd19, 32'd20, 1'b0);
        add_read(32'd10, 32'd21, 32'd22, 1'b0);
        add_read(32'd7, 32'd23, 32'd24, 1'b0);
        add_read(32'd9, 32'd25, 32'd26, 1'b1);
        add_cfg(1'b1);
        // duplicate let through
        add_read(32'd11, 32'd300, 32'd1, 1'b1);
        add_read(32'd11, 32'd400, 32'd2, 1'b0);
        add_read(32'd12, 32'd300, 32'd3, 1'b1);
        add_read(32'd12, 32'd400, 32'd4, 1'b0);

        mixed_traffic(300);
        add_drain();
        mixed_traffic(100);
        add_cfg(1'b0);
        mixed_traffic(200);
        fill_table();
        add_cfg(1'b1);
        mixed_traffic(60);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (plan_q.size() != 0 || start || i_cfg_valid || frag_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
